>>> src/ata_pkg.sv
// Package for the accelerometer tilt-angle block: widths, CORDIC constants
// and the arctangent table. No dependencies.
package ata_pkg;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GUARD_BITS        = 24;
    localparam int GAIN_SHIFT        = 30 - GUARD_BITS;
    localparam int ANGLE_FRAC        = 16;
    localparam int TILT_W            = 15;
    localparam int TABLE_LEN         = 24;
    localparam int ANGLE_W           = 32;
    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 32'sd9001;

    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ANGLE_W-1:0] v;
        case (i)
            5'd0:  v = 32'sd294933724;
            5'd1:  v = 32'sd174109544;
            5'd2:  v = 32'sd91994701;
            5'd3:  v = 32'sd46697947;
            5'd4:  v = 32'sd23439591;
            5'd5:  v = 32'sd11731222;
            5'd6:  v = 32'sd5867043;
            5'd7:  v = 32'sd2933700;
            5'd8:  v = 32'sd1466873;
            5'd9:  v = 32'sd733439;
            5'd10: v = 32'sd366720;
            5'd11: v = 32'sd183360;
            5'd12: v = 32'sd91680;
            5'd13: v = 32'sd45840;
            5'd14: v = 32'sd22920;
            5'd15: v = 32'sd11460;
            5'd16: v = 32'sd5730;
            5'd17: v = 32'sd2865;
            5'd18: v = 32'sd1432;
            5'd19: v = 32'sd716;
            5'd20: v = 32'sd358;
            5'd21: v = 32'sd179;
            5'd22: v = 32'sd90;
            5'd23: v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

>>> src/ata_if.sv
// Request channel interfaces for the tilt-angle block.
// Depends on ata_pkg for the default sample width and the output width.
interface ata_in_if #(parameter int SAMPLE_BITS = ata_pkg::SAMPLE_BITS_DEF);
    logic valid;
    logic ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ata_out_if;
    logic valid;
    logic ready;
    logic signed [ata_pkg::TILT_W-1:0] tilt_x;
    logic signed [ata_pkg::TILT_W-1:0] tilt_y;
    logic signed [ata_pkg::TILT_W-1:0] tilt_z;
    logic zero_vector;
    modport source (output valid, tilt_x, tilt_y, tilt_z, zero_vector, input ready);
    modport sink   (input valid, tilt_x, tilt_y, tilt_z, zero_vector, output ready);
endinterface

>>> src/accel_tilt_angles.sv
// Top level of the accelerometer tilt-angle block: three CORDIC lanes and
// the valid pipeline. Depends on ata_pkg, ata_if and ata_lane.
// One sample enters per cycle while the output is not stalled; each result
// passes through the two chained CORDIC vectoring passes, the gain multiply
// and the rounding stage. The whole pipeline holds while the output request
// is stalled; all-zero samples give zero angles and the zero_vector flag.
module accel_tilt_angles #(
    parameter int SAMPLE_BITS   = ata_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = ata_pkg::CORDIC_STAGES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ata_in_if.sink   i_in,
    ata_out_if.source o_out
);
    localparam int NS  = (CORDIC_STAGES < ata_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                              : ata_pkg::TABLE_LEN;
    localparam int LAT = 2 * NS + 4;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_zero;
    logic           n_en;
    logic signed [ata_pkg::TILT_W-1:0] w_tx, w_ty, w_tz;

    assign n_en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_zero <= {r_zero[LAT-2:0],
                       (i_in.accel_x == '0) && (i_in.accel_y == '0) && (i_in.accel_z == '0)};
        end
    end

    ata_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lx (
        .i_clk(i_clk), .i_en(n_en), .i_a(i_in.accel_x), .i_b(i_in.accel_y),
        .i_c(i_in.accel_z), .o_tilt(w_tx));
    ata_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_ly (
        .i_clk(i_clk), .i_en(n_en), .i_a(i_in.accel_y), .i_b(i_in.accel_x),
        .i_c(i_in.accel_z), .o_tilt(w_ty));
    ata_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lz (
        .i_clk(i_clk), .i_en(n_en), .i_a(i_in.accel_z), .i_b(i_in.accel_x),
        .i_c(i_in.accel_y), .o_tilt(w_tz));

    assign o_out.valid       = r_vld[LAT-1];
    assign o_out.zero_vector = r_zero[LAT-1];
    assign o_out.tilt_x      = r_zero[LAT-1] ? '0 : w_tx;
    assign o_out.tilt_y      = r_zero[LAT-1] ? '0 : w_ty;
    assign o_out.tilt_z      = r_zero[LAT-1] ? '0 : w_tz;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("request dropped under stall");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input held while output empty");
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_vector |-> o_out.tilt_x == '0 && o_out.tilt_z == '0)
        else $error("zero sample gave non-zero angle");
`endif
endmodule

>>> src/ata_lane.sv
// One tilt lane: two pipelined CORDIC vectoring passes, a gain multiply and rounding with clamping.
// Depends on ata_pkg.
module ata_lane #(
    parameter int SAMPLE_BITS   = ata_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = ata_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [SAMPLE_BITS-1:0]         i_a,
    input  logic signed [SAMPLE_BITS-1:0]         i_b,
    input  logic signed [SAMPLE_BITS-1:0]         i_c,
    output logic signed [ata_pkg::TILT_W-1:0]     o_tilt
);
    localparam int NS  = (CORDIC_STAGES < ata_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                              : ata_pkg::TABLE_LEN;
    localparam int DW  = SAMPLE_BITS + ata_pkg::GUARD_BITS + 4;
    localparam int AW  = ata_pkg::ANGLE_W;
    localparam int PW  = SAMPLE_BITS + 32;

    // pass 1 stages 0..NS, pass 2 stages 0..NS
    logic signed [DW-1:0]         r_x1 [NS+1];
    logic signed [DW-1:0]         r_y1 [NS+1];
    logic signed [SAMPLE_BITS-1:0] r_a1 [NS+1];
    logic                          r_sp1 [NS+1];
    logic                          r_pos1 [NS+1];
    logic signed [PW-1:0]          r_prod;
    logic signed [DW-1:0]          r_xp;
    logic                          r_spp, r_posp;
    logic signed [DW-1:0]          r_x2 [NS+1];
    logic signed [DW-1:0]          r_y2 [NS+1];
    logic signed [AW-1:0]          r_z2 [NS+1];
    logic                          r_sp2 [NS+1];
    logic                          r_pos2 [NS+1];
    logic signed [ata_pkg::TILT_W-1:0] r_out;

    logic signed [SAMPLE_BITS:0]   n_absb;
    logic signed [AW-1:0]          n_r;

    assign n_absb = i_b[SAMPLE_BITS-1] ? -{i_b[SAMPLE_BITS-1], i_b} : {i_b[SAMPLE_BITS-1], i_b};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1[0]   <= DW'(n_absb) <<< ata_pkg::GUARD_BITS;
            r_y1[0]   <= DW'(i_c) <<< ata_pkg::GUARD_BITS;
            r_a1[0]   <= i_a;
            r_sp1[0]  <= (i_b == '0) && (i_c == '0);
            r_pos1[0] <= i_a > 0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_p1
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y1[i][DW-1]) begin
                    r_x1[i+1] <= r_x1[i] + (r_y1[i] >>> i);
                    r_y1[i+1] <= r_y1[i] - (r_x1[i] >>> i);
                end else begin
                    r_x1[i+1] <= r_x1[i] - (r_y1[i] >>> i);
                    r_y1[i+1] <= r_y1[i] + (r_x1[i] >>> i);
                end
                r_a1[i+1]   <= r_a1[i];
                r_sp1[i+1]  <= r_sp1[i];
                r_pos1[i+1] <= r_pos1[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(r_a1[NS]) * $signed({1'b0, ata_pkg::GAIN_Q30});
            r_xp   <= r_x1[NS];
            r_spp  <= r_sp1[NS];
            r_posp <= r_pos1[NS];
            r_x2[0]   <= r_xp;
            r_y2[0]   <= DW'(r_prod >>> ata_pkg::GAIN_SHIFT);
            r_z2[0]   <= '0;
            r_sp2[0]  <= r_spp;
            r_pos2[0] <= r_posp;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_p2
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y2[i][DW-1]) begin
                    r_x2[i+1] <= r_x2[i] + (r_y2[i] >>> i);
                    r_y2[i+1] <= r_y2[i] - (r_x2[i] >>> i);
                    r_z2[i+1] <= r_z2[i] + ata_pkg::atan_entry(5'(i));
                end else begin
                    r_x2[i+1] <= r_x2[i] - (r_y2[i] >>> i);
                    r_y2[i+1] <= r_y2[i] + (r_x2[i] >>> i);
                    r_z2[i+1] <= r_z2[i] - ata_pkg::atan_entry(5'(i));
                end
                r_sp2[i+1]  <= r_sp2[i];
                r_pos2[i+1] <= r_pos2[i];
            end
        end
    end

    assign n_r = (r_z2[NS] + AW'(1 << (ata_pkg::ANGLE_FRAC - 1))) >>> ata_pkg::ANGLE_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sp2[NS]) begin
                r_out <= r_pos2[NS] ? ata_pkg::TILT_W'(ata_pkg::ANGLE_LIMIT)
                                    : ata_pkg::TILT_W'(-ata_pkg::ANGLE_LIMIT);
            end else if (n_r > ata_pkg::ANGLE_LIMIT) begin
                r_out <= ata_pkg::TILT_W'(ata_pkg::ANGLE_LIMIT);
            end else if (n_r < -ata_pkg::ANGLE_LIMIT) begin
                r_out <= ata_pkg::TILT_W'(-ata_pkg::ANGLE_LIMIT);
            end else begin
                r_out <= ata_pkg::TILT_W'(n_r);
            end
        end
    end

    assign o_tilt = r_out;
endmodule
